[hw/rtl/elfh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// elfh_pkg: shared types and constants for the ELF hash table builder
// Item and result payloads, field widths, bucket size list, hash helpers.
// ----------------------------------------------------------------------------
package elfh_pkg;

	localparam int MAX_SYMBOLS = 4096;
	localparam int TABLE_WORDS = 8192;

	localparam int ADDR_W   = $clog2(TABLE_WORDS);
	localparam int COUNT_W  = 13;
	localparam int SYMNUM_W = 12;
	localparam int HASH_W   = 28;
	localparam int BKT_W    = 12;
	localparam int WORD_W   = 13;
	localparam int BYTE_W   = 8;

	localparam int NUM_SIZES = 13;
	localparam logic [BKT_W-1:0] BUCKET_SIZES [NUM_SIZES] = '{
		12'd1, 12'd1, 12'd3, 12'd17, 12'd37, 12'd67, 12'd97, 12'd131,
		12'd197, 12'd263, 12'd521, 12'd1031, 12'd2053
	};

	localparam logic MODE_NAME = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [BYTE_W-1:0]   name_byte;
		logic                name_end;
		logic [COUNT_W-1:0]  read_index;
	} in_t;

	typedef struct packed {
		logic [SYMNUM_W-1:0] symbol_number;
		logic [HASH_W-1:0]   hash_value;
		logic [BKT_W-1:0]    bucket_index;
		logic [WORD_W-1:0]   table_word;
		logic                error_flag;
	} out_t;

	// One ELF hash step: shift in the byte, fold the top nibble back at bit 4.
	function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
		input logic [BYTE_W-1:0] c);
		logic [31:0] t;
		logic [31:0] f;
		t = {h, 4'b0000} + {24'd0, c};
		f = t ^ {24'd0, t[31:28], 4'b0000};
		return f[HASH_W-1:0];
	endfunction

	// Largest bucket size not above the symbol count; 1 when the count is 0.
	function automatic logic [BKT_W-1:0] pick_buckets(input logic [COUNT_W-1:0] v);
		logic [BKT_W-1:0] r;
		r = BUCKET_SIZES[0];
		for (int i = 0; i < NUM_SIZES; i++) begin
			if ({1'b0, BUCKET_SIZES[i]} <= v) begin
				r = BUCKET_SIZES[i];
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/elfh_mod.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// elfh_mod: iterative hash remainder unit
// Restoring remainder, one dividend bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module elfh_mod import elfh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] dividend,
	input  logic [BKT_W-1:0]  divisor,
	output logic              done,
	output logic [BKT_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(HASH_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HASH_W-1:0] num_q;
	logic [BKT_W-1:0]  rem_q;
	logic [BKT_W-1:0]  div_q;
	logic [BKT_W:0]    trial;
	logic [BKT_W:0]    diff;
	logic [BKT_W-1:0]  rem_next;

	assign trial    = {rem_q, num_q[HASH_W-1]};
	assign diff     = trial - {1'b0, div_q};
	assign rem_next = (trial >= {1'b0, div_q}) ? diff[BKT_W-1:0] : trial[BKT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(HASH_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: load on start, shift one bit per busy cycle
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[HASH_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

[hw/rtl/elf_hash_table_builder.sv]
`default_nettype none
// A name byte without end mark is taken in idle. A name end runs the remainder unit,
// walks the bucket chain link by link, writes the tail link and gives the result; with a
// full table the walk is skipped. Reads of index 0, 1 or out of range go straight to the
// result, others read the store. One item is in work at a time; a finished result waits
// in the output register. Reset and each symbol_count write sweep all TABLE_WORDS (8192)
// link store words; input stays stalled during the sweep, config writes are taken.
// ----------------------------------------------------------------------------
// elf_hash_table_builder: SysV ELF symbol hash section builder
// Hashes streamed symbol names, links each symbol into its bucket chain in a
// single link store, and serves reads of the section image word by word.
// ----------------------------------------------------------------------------
module elf_hash_table_builder import elfh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_t               out_data
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_WALK,
		ST_READ,
		ST_RESULT
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] count_q;     // symbol count, clamped
	logic [BKT_W-1:0]   chosen_q;    // bucket count
	logic [COUNT_W-1:0] next_sym_q;  // next symbol number to insert
	logic [HASH_W-1:0]  hash_q;      // running name hash
	logic [ADDR_W-1:0]  clr_q;       // clearing pass address
	logic [ADDR_W-1:0]  pos_q;       // store entry whose link is being followed
	out_t               res_q;       // result being assembled
	out_t               out_q;
	logic               out_valid_q;

	// link store: buckets at 0.., chain of symbol s at bucket count + s
	logic [WORD_W-1:0]  mem [TABLE_WORDS];
	logic [WORD_W-1:0]  rdata_q;
	logic [ADDR_W-1:0]  raddr;
	logic               mem_we;
	logic [ADDR_W-1:0]  waddr;
	logic [WORD_W-1:0]  wdata;

	logic               accept;
	logic               is_read;
	logic [HASH_W-1:0]  hash_next;
	logic [COUNT_W:0]   limit;
	logic               read_oor;
	logic               table_full;
	logic [ADDR_W-1:0]  walk_next;
	logic               out_free;
	logic [COUNT_W-1:0] cfg_count;

	logic               mod_start;
	logic               mod_done;
	logic [BKT_W-1:0]   mod_rem;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign is_read   = (in_data.mode == MODE_READ);
	assign hash_next = (in_data.name_byte != '0) ?
		hash_step(hash_q, in_data.name_byte) : hash_q;
	assign limit      = {2'b00, chosen_q} + {1'b0, count_q} + (COUNT_W+1)'(2);
	assign read_oor   = ({1'b0, in_data.read_index} >= limit);
	assign table_full = (next_sym_q >= count_q);
	assign walk_next  = ADDR_W'({1'b0, chosen_q} + rdata_q);
	assign out_free   = !out_valid_q || !out_stall;
	assign cfg_count  = (cfg_wdata > COUNT_W'(MAX_SYMBOLS)) ?
		COUNT_W'(MAX_SYMBOLS) : cfg_wdata;
	assign mod_start  = accept && !is_read && in_data.name_end;

	elfh_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (hash_next),
		.divisor   (chosen_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// store port addressing: read follows the state that needs data next cycle
	always_comb begin
		raddr  = '0;
		mem_we = 1'b0;
		waddr  = pos_q;
		wdata  = next_sym_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_q;
				wdata  = '0;
			end
			ST_IDLE: begin
				raddr = ADDR_W'(in_data.read_index - COUNT_W'(2));
			end
			ST_MOD: begin
				raddr = ADDR_W'(mod_rem);
			end
			ST_WALK: begin
				raddr  = walk_next;
				mem_we = (rdata_q == '0);
			end
			ST_READ, ST_RESULT: begin
				raddr = '0;
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			count_q     <= '0;
			chosen_q    <= BUCKET_SIZES[0];
			next_sym_q  <= COUNT_W'(1);
			hash_q      <= '0;
			clr_q       <= '0;
			pos_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load the output when a result is ready, drop it once transferred
			if (!cfg_we && state_q == ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				// new count: pick buckets, restart numbering, sweep the store
				count_q    <= cfg_count;
				chosen_q   <= pick_buckets(cfg_count);
				next_sym_q <= COUNT_W'(1);
				hash_q     <= '0;
				clr_q      <= '0;
				state_q    <= ST_CLEAR;
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == ADDR_W'(TABLE_WORDS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						// res_q is all zero here unless a count write cut an item short; fill only the fields this item sets
						if (accept) begin
							if (is_read) begin
								if (read_oor) begin
									res_q.error_flag <= 1'b1;
									state_q          <= ST_RESULT;
								end else if (in_data.read_index == COUNT_W'(0)) begin
									res_q.table_word <= WORD_W'(chosen_q);
									state_q          <= ST_RESULT;
								end else if (in_data.read_index == COUNT_W'(1)) begin
									res_q.table_word <= count_q;
									state_q          <= ST_RESULT;
								end else begin
									state_q <= ST_READ;
								end
							end else if (in_data.name_end) begin
								hash_q           <= '0;
								res_q.hash_value <= hash_next;
								state_q          <= ST_MOD;
							end else begin
								hash_q <= hash_next;
							end
						end
					end
					ST_MOD: begin
						if (mod_done) begin
							res_q.bucket_index <= mod_rem;
							pos_q              <= ADDR_W'(mod_rem);
							if (table_full) begin
								res_q.error_flag <= 1'b1;
								state_q          <= ST_RESULT;
							end else begin
								state_q <= ST_WALK;
							end
						end
					end
					ST_WALK: begin
						if (rdata_q == '0) begin
							// tail found: link written this cycle
							res_q.symbol_number <= next_sym_q[SYMNUM_W-1:0];
							next_sym_q          <= next_sym_q + 1'b1;
							state_q             <= ST_RESULT;
						end else begin
							pos_q <= walk_next;
						end
					end
					ST_READ: begin
						res_q.table_word <= rdata_q;
						state_q          <= ST_RESULT;
					end
					ST_RESULT: begin
						if (out_free) begin
							out_q   <= res_q;
							res_q   <= '0;
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// numbering never runs past the count
	a_next_sym_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(next_sym_q <= count_q) || (next_sym_q == COUNT_W'(1)))
		else $error("next symbol beyond symbol count");

	// bucket count never above the symbol count except the minimum
	a_bucket_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, chosen_q} <= count_q) || (chosen_q == BUCKET_SIZES[0]))
		else $error("bucket count above symbol count");

	// remainder unit returns a valid bucket
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD && mod_done) |-> (mod_rem < chosen_q))
		else $error("remainder not below bucket count");

	// a stored link always names a symbol already inserted
	a_link_earlier: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && rdata_q != '0) |-> (rdata_q < next_sym_q))
		else $error("chain link names an uninserted symbol");

endmodule
`default_nettype wire

[bench/tb_elf_hash_table_builder.sv]
// ----------------------------------------------------------------------------
// tb_elf_hash_table_builder: self-checking bench for the ELF hash table builder
// Streams symbol names and section reads through the item channel under
// random bursts and output stalls. A scoreboard model of the hash, the bucket
// chains and the section layout predicts every result. The symbol count is
// reprogrammed between phases, over small counts, a full table and the cap.
// ----------------------------------------------------------------------------
module tb_elf_hash_table_builder;
	import elfh_pkg::*;

	// No transfer for this long means the block is hung. It covers the
	// clearing pass after every count write with plenty of margin.
	localparam int WATCHDOG_LIMIT = 30000;
	// Bucket counts the model may choose, smallest first; 4099 lies above the cap.
	localparam int unsigned PRIME_SIZES [13] = '{
		1, 3, 17, 37, 67, 97, 131, 197, 263, 521, 1031, 2053, 4099
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_t                in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_t               out_data;

	elf_hash_table_builder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Scoreboard model: its own copy of the count, bucket choice, symbol
	// numbering, running hash and the bucket/chain store.
	// ------------------------------------------------------------------
	int unsigned       sym_count;
	int unsigned       n_buckets;
	int unsigned       next_sym;
	logic [HASH_W-1:0] hash_acc;
	logic [WORD_W-1:0] link_mem [TABLE_WORDS];
	out_t              result_q [$];
	in_t               item_q [$];
	int unsigned       n_fail = 0;

	// Count write: cap, pick the bucket count, wipe the store, restart numbering.
	task automatic load_symbol_count(input logic [COUNT_W-1:0] v);
		int unsigned capped;
		capped = (v > MAX_SYMBOLS) ? MAX_SYMBOLS : v;
		sym_count = capped;
		n_buckets = 1;
		foreach (PRIME_SIZES[i])
			if (PRIME_SIZES[i] <= capped)
				n_buckets = PRIME_SIZES[i];
		foreach (link_mem[i])
			link_mem[i] = '0;
		next_sym = 1;
		hash_acc = '0;
	endtask

	// Advance the model by one accepted item and queue the result it causes.
	task automatic model_item(input in_t it);
		out_t              r;
		logic [31:0]       t;
		int unsigned       pos;
		int unsigned       walked;
		int unsigned       lim;
		logic [WORD_W-1:0] lnk;
		r = '0;
		if (it.mode == MODE_READ) begin
			// Section image: bucket count, chain count, buckets, chains.
			lim = n_buckets + sym_count + 2;
			if (it.read_index >= lim) begin
				r.error_flag = 1'b1;
			end else if (it.read_index == 0) begin
				r.table_word = WORD_W'(n_buckets);
			end else if (it.read_index == 1) begin
				r.table_word = WORD_W'(sym_count);
			end else begin
				r.table_word = link_mem[it.read_index - 2];
			end
			result_q.push_back(r);
		end else begin
			// A zero byte leaves the hash alone; otherwise shift in the byte
			// and fold the top nibble back in at bit 4.
			if (it.name_byte != 0) begin
				t = {hash_acc, 4'h0} + 32'(it.name_byte);
				t = t ^ {24'h0, t[31:28], 4'h0};
				hash_acc = t[HASH_W-1:0];
			end
			if (it.name_end) begin
				pos = hash_acc % n_buckets;
				r.hash_value = hash_acc;
				r.bucket_index = BKT_W'(pos);
				hash_acc = '0;
				if (next_sym >= sym_count) begin
					// Table full: report, insert nothing, keep the number.
					r.error_flag = 1'b1;
				end else begin
					// Walk to the tail of the bucket's chain and link in.
					lnk = link_mem[pos];
					walked = 0;
					while (lnk != 0 && walked <= MAX_SYMBOLS) begin
						pos = n_buckets + lnk;
						lnk = link_mem[pos];
						walked++;
					end
					link_mem[pos] = WORD_W'(next_sym);
					r.symbol_number = SYMNUM_W'(next_sym);
					next_sym++;
				end
				result_q.push_back(r);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_fail++;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers: they only queue items, the driver paces them.
	// ------------------------------------------------------------------
	task automatic push_item(input logic mode, input logic [BYTE_W-1:0] b,
		input logic e, input logic [COUNT_W-1:0] idx);
		in_t it;
		it.mode = mode;
		it.name_byte = b;
		it.name_end = e;
		it.read_index = idx;
		item_q.push_back(it);
	endtask

	// Mostly in range over the current image, now and then past its end.
	task automatic push_read();
		int unsigned lim;
		lim = n_buckets + sym_count + 2;
		if ($urandom_range(6, 0) == 0)
			push_item(MODE_READ, BYTE_W'($urandom), 1'($urandom),
				COUNT_W'($urandom_range(8191, lim)));
		else
			push_item(MODE_READ, BYTE_W'($urandom), 1'($urandom),
				COUNT_W'($urandom_range(lim - 1, 0)));
	endtask

	// One symbol name; a read may slip in between its bytes.
	task automatic push_name(input int len);
		logic [BYTE_W-1:0] b;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9, 0))
				0:       b = 8'h00;
				1, 2:    b = BYTE_W'($urandom_range(255, 128));
				default: b = BYTE_W'($urandom_range(126, 33));
			endcase
			if ($urandom_range(19, 0) == 0)
				push_read();
			push_item(MODE_NAME, b, i == len - 1, COUNT_W'($urandom));
		end
	endtask

	// Roughly n items of names and reads for the count just loaded.
	task automatic fill_phase(input int n);
		int made;
		int len;
		made = 0;
		while (made < n) begin
			if ($urandom_range(4, 0) == 0) begin
				push_read();
				made++;
			end else begin
				len = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 9)
					: $urandom_range(8, 1);
				push_name(len);
				made += len;
			end
		end
	endtask

	// Hold until every item is sent and every result is back, then let the
	// block settle before touching the count register.
	task automatic wait_drained();
		while (item_q.size() != 0 || in_valid || result_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		load_symbol_count(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Driver: send in bursts of random length with random gaps. A new item
	// goes out only once the previous one was taken by a transfer.
	// ------------------------------------------------------------------
	logic        in_fired = 1'b0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fired) begin
			if (gap_left != 0 || item_q.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left != 0)
					gap_left <= gap_left - 1;
			end else begin
				in_valid <= 1'b1;
				in_data <= item_q.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(24, 1);
					// A quarter of the bursts run straight into the next one.
					gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver stall pattern: a repeating frame of open, random, mostly
	// stalled and sparse stretches.
	logic [7:0] stall_tick = '0;

	always @(negedge clk) begin
		stall_tick <= stall_tick + 8'd1;
		case (stall_tick[7:5])
			3'd0, 3'd1: out_stall <= 1'b0;
			3'd2:       out_stall <= 1'($urandom_range(1, 0));
			3'd3:       out_stall <= stall_tick[1:0] != 2'd0;
			3'd5:       out_stall <= $urandom_range(3, 0) != 0;
			default:    out_stall <= $urandom_range(3, 0) == 0;
		endcase
	end

	// ------------------------------------------------------------------
	// Monitor: feed accepted items to the model, compare accepted results
	// with the oldest prediction, and watch for a hang.
	// ------------------------------------------------------------------
	out_t        want;
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		in_fired <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			model_item(in_data);
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$error("result with nothing outstanding: %p", out_data);
				n_fail++;
			end else begin
				want = result_q.pop_front();
				check_field("symbol_number", 32'(want.symbol_number),
					32'(out_data.symbol_number));
				check_field("hash_value", 32'(want.hash_value),
					32'(out_data.hash_value));
				check_field("bucket_index", 32'(want.bucket_index),
					32'(out_data.bucket_index));
				check_field("table_word", 32'(want.table_word),
					32'(out_data.table_word));
				check_field("error_flag", 32'(want.error_flag),
					32'(out_data.error_flag));
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence: directed items on a three-symbol table, then random
	// phases over a spread of counts, each after a fresh count write.
	// ------------------------------------------------------------------
	int unsigned phase_counts [10] = '{0, 1, 2, 16, 17, 250, 8191, 4096, 1031, 37};
	int          phase_items  [10] = '{60, 60, 60, 200, 200, 300, 300, 200, 250, 200};

	initial begin
		load_symbol_count('0);
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Count 3: three buckets, room for symbols 1 and 2 only.
		write_count(13'd3);
		// Eight 0xFF bytes push bits past 28 and exercise the nibble fold.
		for (int i = 0; i < 8; i++)
			push_item(MODE_NAME, 8'hFF, i == 7, 13'h1FFF);
		// A read in the middle of a name leaves the running hash alone.
		push_item(MODE_NAME, 8'h78, 1'b0, '0);
		push_item(MODE_READ, 8'hA5, 1'b1, 13'd0);
		push_item(MODE_NAME, 8'h00, 1'b1, '0);
		// Empty name once the table is full: flagged, not inserted.
		push_item(MODE_NAME, 8'h00, 1'b1, 13'h1555);
		// Walk the whole image, then step just past its end and to the top.
		for (int i = 1; i <= 8; i++)
			push_item(MODE_READ, 8'hA5, 1'b1, COUNT_W'(i));
		push_item(MODE_READ, 8'h5A, 1'b0, 13'h1FFF);
		push_item(MODE_NAME, 8'h01, 1'b1, 13'h0AAA);

		foreach (phase_counts[p]) begin
			wait_drained();
			write_count(COUNT_W'(phase_counts[p]));
			fill_phase(phase_items[p]);
		end
		wait_drained();
		repeat (60) @(posedge clk);

		if (n_fail == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[elf_hash_table_builder.f]
hw/rtl/elfh_pkg.sv
hw/rtl/elfh_mod.sv
hw/rtl/elf_hash_table_builder.sv
bench/tb_elf_hash_table_builder.sv
